@@ sv/nnsck_pkg.sv @@
// Shared types and constants for the nearest-neighbor scaler with color key.
// No dependencies; imported by every module of the block.
package nnsck_pkg;

    localparam int PIX_IDX_W  = 16;
    localparam int COORD_W    = 12;
    localparam int SRC_DIM_W  = 9;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 32;
    localparam int PROD_W     = COORD_W + SRC_DIM_W;
    localparam int QUOT_W     = SRC_DIM_W;
    localparam int CNT_W      = $clog2(QUOT_W + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 72;
    localparam int MAX_DIM    = 256;

    localparam logic [23:0] RGB_MASK = 24'hFF_FFFF;

    // request kinds carried on the input tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // result status carried on the output tuser
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_START,
        S_DIV,
        S_ADDR,
        S_READ,
        S_KEY
    } seq_state_t;

endpackage

@@ sv/nnsck_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nnsck_pkg; the quotient is known to fit in QUOT_W bits.
module nnsck_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [nnsck_pkg::PROD_W-1:0]   dividend,
    input  logic [nnsck_pkg::COORD_W-1:0]  divisor,
    output logic                           busy,
    output logic [nnsck_pkg::QUOT_W-1:0]   quotient
);
    import nnsck_pkg::*;

    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0]  num_reg, num_next;
    logic [COORD_W-1:0] div_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COORD_W:0]   trial;
    logic [COORD_W:0]   diff;
    logic               take;

    always_comb begin
        trial    = {rem_reg, num_reg[QUOT_W-1]};
        diff     = trial - {1'b0, div_reg};
        take     = (trial >= {1'b0, div_reg});
        rem_next = take ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
        num_next = {num_reg[QUOT_W-2:0], take};
        cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(QUOT_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // upper dividend bits are already below the divisor
            rem_reg <= dividend[PROD_W-1:QUOT_W];
            num_reg <= dividend[QUOT_W-1:0];
            div_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = num_reg;

endmodule

@@ sv/nnsck_store.sv @@
// Source pixel store: one write port, one read port with registered data.
// Depends on nnsck_pkg for index and word widths.
module nnsck_store (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [nnsck_pkg::PIX_IDX_W-1:0]  wr_addr,
    input  logic [nnsck_pkg::PIXEL_W-1:0]    wr_data,
    input  logic                             rd_en,
    input  logic [nnsck_pkg::PIX_IDX_W-1:0]  rd_addr,
    output logic [nnsck_pkg::PIXEL_W-1:0]    rd_data
);
    import nnsck_pkg::*;

    logic [PIXEL_W-1:0] mem [1 << PIX_IDX_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/nearest_neighbor_scaler_color_key.sv @@
// Top level of the nearest-neighbor scaler with color key.
// Depends on nnsck_pkg, nnsck_div and nnsck_store.
//
// Usage:
//   The input stream carries two kinds of item, chosen by s_axis_tuser.
//   A write item stores one RGBA pixel at a linear index of the pixel
//   store; it gives no result. A read item names a
//   target coordinate; the block maps it to the source grid with
//   floor(x*srcW/dstW), floor(y*srcH/dstH) and returns one ARGB word on
//   the output stream, with alpha forced to zero on a color-key match.
//   A coordinate outside the target size returns a zero pixel with an
//   error status on m_axis_tuser. An in-range read passes through a
//   multiply, a divider load, nine divider steps (one quotient bit each),
//   the address sum, the store read, the read data return and the key
//   check. Items are worked one at a time, so a new item is accepted
//   only once the last one has left the key stage.
//   A result waits in the output register while the receiver
//   stalls; the next item is still accepted and holds in its key stage
//   until the register is free. Reset clears the sequencer, the output
//   valid and the registers (source 1x1, target 0x0, key off), not the
//   pixel store. Write configuration through cfg_wr_* only while idle.
module nearest_neighbor_scaler_color_key (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [nnsck_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [nnsck_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_index[15:0], in_red[23:16], in_green[31:24], in_blue[39:32],
    // in_alpha[47:40], target_x[59:48], target_y[71:60]
    input  logic [nnsck_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // req_type[0]
    input  logic                              s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_pixel[31:0]
    output logic [nnsck_pkg::PIXEL_W-1:0]     m_axis_tdata,
    // out_status[0]
    output logic                              m_axis_tuser
);
    import nnsck_pkg::*;

    // configuration registers
    logic [SRC_DIM_W-1:0] src_width_reg;
    logic [SRC_DIM_W-1:0] src_height_reg;
    logic [COORD_W-1:0]   dst_width_reg;
    logic [COORD_W-1:0]   dst_height_reg;
    logic [PIXEL_W-1:0]   color_key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= SRC_DIM_W'(1);
            src_height_reg <= SRC_DIM_W'(1);
            dst_width_reg  <= '0;
            dst_height_reg <= '0;
            color_key_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_wr_data[SRC_DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_wr_data[SRC_DIM_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_wr_data[COORD_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= cfg_wr_data[COORD_W-1:0];
                REG_COLOR_KEY:  color_key_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // effective sizes: zero source size acts as one, large sizes saturate,
    // zero target size follows the source
    logic [SRC_DIM_W-1:0] src_w, src_h;
    logic [COORD_W-1:0]   tgt_w, tgt_h;

    always_comb begin
        if (src_width_reg == '0) begin
            src_w = SRC_DIM_W'(1);
        end else if (COORD_W'(src_width_reg) > COORD_W'(MAX_DIM)) begin
            src_w = SRC_DIM_W'(MAX_DIM);
        end else begin
            src_w = src_width_reg;
        end
        if (src_height_reg == '0) begin
            src_h = SRC_DIM_W'(1);
        end else if (COORD_W'(src_height_reg) > COORD_W'(MAX_DIM)) begin
            src_h = SRC_DIM_W'(MAX_DIM);
        end else begin
            src_h = src_height_reg;
        end
        tgt_w = (dst_width_reg  != '0) ? dst_width_reg  : COORD_W'(src_w);
        tgt_h = (dst_height_reg != '0) ? dst_height_reg : COORD_W'(src_h);
    end

    // unpack the input item
    logic [PIX_IDX_W-1:0] in_index;
    logic [CHAN_W-1:0]    in_red, in_green, in_blue, in_alpha;
    logic [COORD_W-1:0]   in_x, in_y;

    assign in_index = s_axis_tdata[15:0];
    assign in_red   = s_axis_tdata[23:16];
    assign in_green = s_axis_tdata[31:24];
    assign in_blue  = s_axis_tdata[39:32];
    assign in_alpha = s_axis_tdata[47:40];
    assign in_x     = s_axis_tdata[59:48];
    assign in_y     = s_axis_tdata[71:60];

    // sequencer
    seq_state_t state_reg, state_next;
    logic       accept;
    logic       out_free;
    logic       div_start;
    logic       rd_en;
    logic       res_load;
    logic       x_busy, y_busy;
    logic       in_range;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign in_range = (in_x < tgt_w) && (in_y < tgt_h);

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        rd_en         = 1'b0;
        res_load      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && s_axis_tuser == REQ_READ) begin
                    state_next = in_range ? S_MUL : S_KEY;
                end
            end
            S_MUL: begin
                state_next = S_START;
            end
            S_START: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (!x_busy) begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                rd_en      = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                state_next = S_KEY;
            end
            S_KEY: begin
                // hold the result until the output register is free
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // read datapath
    logic [COORD_W-1:0]   x_reg, y_reg;
    logic                 oor_reg;
    logic [PROD_W-1:0]    x_prod_reg, y_prod_reg;
    logic [PIX_IDX_W-1:0] rd_idx_reg;
    logic [QUOT_W-1:0]    src_x, src_y;
    logic [2*SRC_DIM_W:0] idx_sum;

    assign idx_sum = (2*SRC_DIM_W+1)'(src_y) * (2*SRC_DIM_W+1)'(src_w)
                   + (2*SRC_DIM_W+1)'(src_x);

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= in_x;
            y_reg   <= in_y;
            oor_reg <= !in_range;
        end
        if (state_reg == S_MUL) begin
            x_prod_reg <= PROD_W'(x_reg) * PROD_W'(src_w);
            y_prod_reg <= PROD_W'(y_reg) * PROD_W'(src_h);
        end
        if (state_reg == S_DIV && !x_busy) begin
            rd_idx_reg <= idx_sum[PIX_IDX_W-1:0];
        end
    end

    nnsck_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (x_prod_reg),
        .divisor  (tgt_w),
        .busy     (x_busy),
        .quotient (src_x)
    );

    nnsck_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (y_prod_reg),
        .divisor  (tgt_h),
        .busy     (y_busy),
        .quotient (src_y)
    );

    // pixel store; writes land in the accept cycle, stored as ARGB
    logic [PIXEL_W-1:0] rd_pixel;
    logic               wr_en;

    assign wr_en = accept && s_axis_tuser == REQ_WRITE;

    nnsck_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (in_index),
        .wr_data ({in_alpha, in_red, in_green, in_blue}),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_pixel)
    );

    // color key: drop alpha when the RGB matches an enabled key
    logic               key_hit;
    logic [PIXEL_W-1:0] res_pixel;

    always_comb begin
        key_hit = (color_key_reg != '0) && (rd_pixel[23:0] == (color_key_reg[23:0] & RGB_MASK));
        if (oor_reg) begin
            res_pixel = '0;
        end else begin
            res_pixel = {key_hit ? 8'h00 : rd_pixel[31:24], rd_pixel[23:0]};
        end
    end

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0] m_data_reg;
    logic               m_user_reg;

    always_comb begin
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= res_pixel;
            m_user_reg <= oor_reg ? ST_RANGE : ST_OK;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // both divider lanes start together and run the same step count
    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> x_busy == y_busy)
        else $error("divider lanes out of step");

    // an accepted read always starts work
    a_read_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tuser == REQ_READ) |=> state_reg != S_IDLE)
        else $error("read item dropped");

    // a new result appears only out of the key stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg ##1 m_valid_reg) |-> $past(state_reg == S_KEY))
        else $error("result without key stage");

    // out-of-range results carry a zero pixel
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ST_RANGE) |-> m_axis_tdata == '0)
        else $error("range error with nonzero pixel");

endmodule

@@ test/nearest_neighbor_scaler_color_key_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for nearest_neighbor_scaler_color_key: streams pixel writes
// and scaled reads, predicts each result in-bench and checks it field by field.
// Depends on nnsck_pkg and the nearest_neighbor_scaler_color_key RTL only.
module nearest_neighbor_scaler_color_key_tb;

    import nnsck_pkg::*;

    // generous bound: ~1.1k items, plus the hold
    localparam int CYCLE_LIMIT  = 500000;
    // let any trailing work finish
    localparam int SETTLE       = 20;
    localparam int HOLD_CYCLES  = 500;
    localparam int RAND_PHASES  = 9;
    localparam int PHASE_ITEMS  = 95;

    typedef struct {
        logic        kind;
        logic [15:0] index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] tx;
        logic [11:0] ty;
    } pixel_req_t;

    typedef struct {
        logic [31:0] pixel;
        logic        status;
    } scaled_pixel_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIXEL_W-1:0]    m_axis_tdata;
    logic                  m_axis_tuser;

    // shadow copy of the geometry and key registers
    logic [8:0]  img_w    = 9'd1;
    logic [8:0]  img_h    = 9'd1;
    logic [11:0] out_w    = 12'd0;
    logic [11:0] out_h    = 12'd0;
    logic [31:0] key_argb = 32'd0;

    // predicted pixel store, and which entries the stimulus has filled
    logic [31:0] pixel_store [65536];
    bit          loaded      [65536];

    pixel_req_t    pending_reqs[$];
    scaled_pixel_t expected_pixels[$];
    pixel_req_t    offered;
    scaled_pixel_t want;

    bit steady    = 1'b0;   // no idling on either side while set
    bit squeeze   = 1'b0;   // ask the receiver for one long hold-off
    bit squeezed  = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches  = 0;

    nearest_neighbor_scaler_color_key dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Geometry helpers
    // ------------------------------------------------------------------

    // zero counts as one, anything above MAX_DIM saturates
    function automatic int clamp_dim(logic [8:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int target_w();
        return (out_w != 0) ? int'(out_w) : clamp_dim(img_w);
    endfunction

    function automatic int target_h();
        return (out_h != 0) ? int'(out_h) : clamp_dim(img_h);
    endfunction

    function automatic bit in_target(logic [11:0] tx, logic [11:0] ty);
        return int'(tx) < target_w() && int'(ty) < target_h();
    endfunction

    // nearest source pixel for a target coordinate, as a wrapped linear index
    function automatic logic [15:0] source_index(logic [11:0] tx, logic [11:0] ty);
        int sw;
        int sx;
        int sy;
        logic [31:0] lin;
        sw  = clamp_dim(img_w);
        sx  = (int'(tx) * sw) / target_w();
        sy  = (int'(ty) * clamp_dim(img_h)) / target_h();
        lin = sy * sw + sx;
        return lin[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Prediction: update the store on writes, queue the result of reads
    // ------------------------------------------------------------------
    task automatic apply_request(pixel_req_t r);
        logic [31:0] pix;
        logic [7:0]  alpha;
        if (r.kind == REQ_WRITE) begin
            pixel_store[r.index] = {r.alpha, r.red, r.green, r.blue};
        end else if (!in_target(r.tx, r.ty)) begin
            expected_pixels.push_back('{pixel: 32'h0, status: ST_RANGE});
        end else begin
            pix   = pixel_store[source_index(r.tx, r.ty)];
            alpha = pix[31:24];
            // color key: any nonzero key enables, only RGB is compared
            if (key_argb != 0 && pix[23:0] == key_argb[23:0]) alpha = 8'h00;
            expected_pixels.push_back('{pixel: {alpha, pix[23:0]}, status: ST_OK});
        end
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // random pixel; a quarter of them hit the key color when a key is on
    function automatic logic [31:0] random_pixel();
        logic [31:0] p;
        p = $urandom;
        if (key_argb != 0 && $urandom_range(0, 3) == 0) p[23:0] = key_argb[23:0];
        return p;
    endfunction

    task automatic queue_write(logic [15:0] idx, logic [31:0] argb);
        pixel_req_t r;
        r.kind  = REQ_WRITE;
        r.index = idx;
        r.alpha = argb[31:24];
        r.red   = argb[23:16];
        r.green = argb[15:8];
        r.blue  = argb[7:0];
        // coordinates are unused on a write; keep them moving anyway
        r.tx    = 12'($urandom);
        r.ty    = 12'($urandom);
        pending_reqs.push_back(r);
        loaded[idx] = 1'b1;
    endtask

    // a read of a never-written pixel is out of contract: fill it first
    task automatic queue_read(logic [11:0] tx, logic [11:0] ty);
        pixel_req_t r;
        logic [31:0] noise;
        if (in_target(tx, ty) && !loaded[source_index(tx, ty)])
            queue_write(source_index(tx, ty), random_pixel());
        noise   = $urandom;
        r.kind  = REQ_READ;
        r.index = noise[15:0];
        r.red   = noise[23:16];
        r.green = noise[31:24];
        noise   = $urandom;
        r.blue  = noise[7:0];
        r.alpha = noise[15:8];
        r.tx    = tx;
        r.ty    = ty;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(int count);
        int roll;
        int tx;
        int ty;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                // mostly in-range reads, some anywhere on the 12-bit grid
                tx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, target_w() - 1)
                                                : $urandom_range(0, 4095);
                ty = ($urandom_range(0, 9) < 8) ? $urandom_range(0, target_h() - 1)
                                                : $urandom_range(0, 4095);
                queue_read(12'(tx), 12'(ty));
            end else if (roll < 90) begin
                queue_write(16'($urandom_range(0, clamp_dim(img_h) - 1) * clamp_dim(img_w)
                                + $urandom_range(0, clamp_dim(img_w) - 1)),
                            random_pixel());
            end else begin
                // stray write anywhere in the 16-bit store
                queue_write(16'($urandom), $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration: one register per clock, only while the block is idle
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        case (idx)
            REG_SRC_WIDTH:  img_w    = val[8:0];
            REG_SRC_HEIGHT: img_h    = val[8:0];
            REG_DST_WIDTH:  out_w    = val[11:0];
            REG_DST_HEIGHT: out_h    = val[11:0];
            REG_COLOR_KEY:  key_argb = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(int sw, int sh, int dw, int dh, logic [31:0] key);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_COLOR_KEY, key);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold until every item is sent and every result is back, then settle
    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next pending item, predict on every accept
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) apply_request(offered);
            // the slot is free when nothing is shown or the shown item just went
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 35)) begin
                    offered = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {offered.ty, offered.tx, offered.alpha, offered.blue,
                                      offered.green, offered.red, offered.index};
                    s_axis_tuser  <= offered.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random backpressure, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (squeeze && !squeezed) begin
                squeezed  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result pixel=%h status=%0d",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata !== want.pixel)
                    report_mismatch($sformatf("out_pixel got %h want %h",
                                              m_axis_tdata, want.pixel));
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("out_status got %0d want %0d",
                                              m_axis_tuser, want.status));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry: 1x1 source, target follows source, key off
        queue_write(16'h0000, 32'hFF123456);
        queue_read(12'd0, 12'd0);
        queue_read(12'd1, 12'd0);
        queue_read(12'd0, 12'd1);
        queue_read(12'hFFF, 12'hFFF);
        queue_write(16'hFFFF, 32'hFFFF_FFFF);
        queue_write(16'h0000, 32'h0000_0000);
        queue_read(12'd0, 12'd0);
        drain();

        // 4x3 source at native size; key match drops alpha, near miss keeps it
        set_geometry(4, 3, 0, 0, 32'h00AB_CDEF);
        queue_write(16'd11, 32'h80AB_CDEF);
        queue_read(12'd3, 12'd2);
        queue_write(16'd0, 32'h7FAB_CDEE);
        queue_read(12'd0, 12'd0);
        queue_read(12'd4, 12'd0);
        queue_read(12'd0, 12'd3);
        drain();

        // zero source size acts as 1x1; widest target; all-ones key
        set_geometry(0, 0, 4095, 4095, 32'hFFFF_FFFF);
        queue_write(16'd0, 32'hFFFF_FFFF);
        queue_read(12'd4094, 12'd4094);
        queue_read(12'd4095, 12'd0);
        drain();

        // oversize source saturates to MAX_DIM; 1x1 target; key with only
        // alpha set still enables and matches black
        set_geometry(511, 511, 1, 1, 32'hFF00_0000);
        queue_write(16'd0, 32'h1200_0000);
        queue_read(12'd0, 12'd0);
        queue_read(12'd1, 12'd1);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin
                    // back-to-back traffic, no gaps on either side
                    set_geometry(511, 3, 4095, 0, 32'd0);
                    steady <= 1'b1;
                end
                1: set_geometry(256, 256, 4095, 4095, $urandom);
                2: begin
                    // receiver stalls long enough to back up the input
                    set_geometry(5, 4, 16, 9, $urandom);
                    squeeze <= 1'b1;
                end
                default: begin
                    set_geometry(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                             : $urandom_range(1, 16),
                                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                             : $urandom_range(1, 16),
                                 ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 40),
                                 ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 40),
                                 ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom);
                end
            endcase
            queue_random(PHASE_ITEMS);
            drain();
            steady <= 1'b0;
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
